### src/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types, widths and codes of the DFA state minimizer.
// ----------------------------------------------------------------------------
package dsm_pkg;

	// default sizes of the automaton store
	localparam int unsigned MAX_STATES_DEF  = 64;
	localparam int unsigned MAX_SYMBOLS_DEF = 16;

	// fixed field widths
	localparam int unsigned STATE_W     = 6;
	localparam int unsigned SYMBOL_W    = 4;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned SYM_COUNT_W = 5;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 7;
	localparam int unsigned TRANS_W     = STATE_W + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 1'b1;

	// configuration reset values
	localparam logic [COUNT_W-1:0]     STATE_COUNT_RST  = 7'd64;
	localparam logic [SYM_COUNT_W-1:0] SYMBOL_COUNT_RST = 5'd16;

	typedef struct packed {
		logic [STATE_W-1:0]  source_state;
		logic [SYMBOL_W-1:0] symbol_index;
		logic [STATE_W-1:0]  target_state;
		logic                target_present;
		logic                is_accepting;
		logic                last_entry;
	} item_t;

	typedef struct packed {
		logic [STATE_W-1:0] original_state;
		logic [STATE_W-1:0] block_number;
		logic               block_accepting;
		logic [COUNT_W-1:0] block_count;
		logic               last_result;
	} result_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT_RD,
		ST_INIT_WR,
		ST_S_RD,
		ST_S_LAT,
		ST_T_RD,
		ST_T_CHK,
		ST_A_RD,
		ST_A_LBL,
		ST_A_CHK,
		ST_PASS_END,
		ST_CNT_RD,
		ST_CNT_CHK,
		ST_OUT_RD,
		ST_OUT_ACC,
		ST_OUT_SEND
	} seq_state_t;

endpackage

### src/dsm_ram.sv
// ----------------------------------------------------------------------------
// dsm_ram
// Memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dsm_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re_a,
	input  logic [ADDR_W-1:0] raddr_a,
	output logic [DATA_W-1:0] rdata_a,
	input  logic              re_b,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem_q [(1 << ADDR_W)];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### src/dsm_seq.sv
// ----------------------------------------------------------------------------
// dsm_seq
// Load, partition refinement and result sequencer with its memories.
// ----------------------------------------------------------------------------
module dsm_seq #(
	parameter int unsigned MAX_STATES  = dsm_pkg::MAX_STATES_DEF,
	parameter int unsigned MAX_SYMBOLS = dsm_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(MAX_STATES+1)-1:0]     n_eff,
	input  logic [$clog2(MAX_SYMBOLS+1)-1:0]    k_eff,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  dsm_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output dsm_pkg::result_t                    result
);

	localparam int unsigned SW  = $clog2(MAX_STATES);
	localparam int unsigned AW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int unsigned NW  = $clog2(MAX_STATES+1);
	localparam int unsigned TAW = SW + AW;

	dsm_pkg::seq_state_t state_q, state_nx;

	logic [SW-1:0]  s_q, t_q, ps_q, blk_q, first0_q, first1_q;
	logic           first0_v_q, first1_v_q;
	logic [AW-1:0]  a_q;
	logic [TAW-1:0] clr_q;
	logic           clr_acc_q;
	logic           rd_bank_q;
	logic           changed_q;
	logic           pres_s_q, pres_t_q;
	logic [NW-1:0]  count_q;

	// memory ports
	logic                         tr_we, tr_re;
	logic [TAW-1:0]               tr_waddr, tr_raddr_a, tr_raddr_b;
	logic [dsm_pkg::TRANS_W-1:0]  tr_wdata, tr_rdata_a, tr_rdata_b;
	logic                         ac_we, ac_re_a, ac_re_b, ac_wdata;
	logic [SW-1:0]                ac_waddr, ac_raddr_a, ac_raddr_b;
	logic                         ac_rdata_a, ac_rdata_b;
	logic                         lb_we, lb_re_a, lb_re_b;
	logic [SW-1:0]                lb_waddr, lb_wdata, lb_raddr_a, lb_raddr_b;
	logic [SW-1:0]                lb0_rdata_a, lb0_rdata_b, lb1_rdata_a, lb1_rdata_b;
	logic [SW-1:0]                lb_rdata_a, lb_rdata_b;

	// decode helpers
	logic s_last, t_eq_s, a_last, clr_last, sig_eq, load_trans, load_acc;
	logic init_acc_lbl_sel;
	logic [SW-1:0] init_label;
	logic pres_s, pres_t;

	dsm_ram #(.DATA_W(dsm_pkg::TRANS_W), .ADDR_W(TAW)) u_trans (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.re_a(tr_re), .raddr_a(tr_raddr_a), .rdata_a(tr_rdata_a),
		.re_b(tr_re), .raddr_b(tr_raddr_b), .rdata_b(tr_rdata_b)
	);

	dsm_ram #(.DATA_W(1), .ADDR_W(SW)) u_accept (
		.clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
		.re_a(ac_re_a), .raddr_a(ac_raddr_a), .rdata_a(ac_rdata_a),
		.re_b(ac_re_b), .raddr_b(ac_raddr_b), .rdata_b(ac_rdata_b)
	);

	dsm_ram #(.DATA_W(SW), .ADDR_W(SW)) u_label0 (
		.clk(clk), .we(lb_we && rd_bank_q), .waddr(lb_waddr), .wdata(lb_wdata),
		.re_a(lb_re_a), .raddr_a(lb_raddr_a), .rdata_a(lb0_rdata_a),
		.re_b(lb_re_b), .raddr_b(lb_raddr_b), .rdata_b(lb0_rdata_b)
	);

	dsm_ram #(.DATA_W(SW), .ADDR_W(SW)) u_label1 (
		.clk(clk), .we(lb_we && !rd_bank_q), .waddr(lb_waddr), .wdata(lb_wdata),
		.re_a(lb_re_a), .raddr_a(lb_raddr_a), .rdata_a(lb1_rdata_a),
		.re_b(lb_re_b), .raddr_b(lb_raddr_b), .rdata_b(lb1_rdata_b)
	);

	// snapshot labels come from the read bank
	assign lb_rdata_a = rd_bank_q ? lb1_rdata_a : lb0_rdata_a;
	assign lb_rdata_b = rd_bank_q ? lb1_rdata_b : lb0_rdata_b;

	// loop ends and compares
	assign s_last   = (32'(s_q) == (32'(n_eff) - 32'd1));
	assign t_eq_s   = (t_q == s_q);
	assign a_last   = (32'(a_q) == (32'(k_eff) - 32'd1));
	assign clr_last = (clr_q == '1);

	// a stored target at or beyond the state count is absent
	assign pres_s = tr_rdata_a[dsm_pkg::STATE_W] &&
		(32'(tr_rdata_a[dsm_pkg::STATE_W-1:0]) < 32'(n_eff));
	assign pres_t = tr_rdata_b[dsm_pkg::STATE_W] &&
		(32'(tr_rdata_b[dsm_pkg::STATE_W-1:0]) < 32'(n_eff));
	assign sig_eq = (pres_s_q == pres_t_q) && (!pres_s_q || (lb_rdata_a == lb_rdata_b));

	// load qualifiers
	assign load_acc   = (32'(item.source_state) < 32'(MAX_STATES));
	assign load_trans = load_acc && item.target_present &&
		(32'(item.symbol_index) < 32'(MAX_SYMBOLS));

	// first split: lowest state with the same accepting flag
	assign init_acc_lbl_sel = ac_rdata_a;
	always_comb begin
		if (init_acc_lbl_sel) begin
			init_label = first1_v_q ? first1_q : s_q;
		end else begin
			init_label = first0_v_q ? first0_q : s_q;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dsm_pkg::ST_CLEAR:    if (clr_last) state_nx = dsm_pkg::ST_IDLE;
			dsm_pkg::ST_IDLE:     if (item_valid && item.last_entry) state_nx = dsm_pkg::ST_INIT_RD;
			dsm_pkg::ST_INIT_RD:  state_nx = dsm_pkg::ST_INIT_WR;
			dsm_pkg::ST_INIT_WR:  state_nx = s_last ? dsm_pkg::ST_S_RD : dsm_pkg::ST_INIT_RD;
			dsm_pkg::ST_S_RD:     state_nx = dsm_pkg::ST_S_LAT;
			dsm_pkg::ST_S_LAT:    state_nx = dsm_pkg::ST_T_RD;
			dsm_pkg::ST_T_RD: begin
				if (!t_eq_s) state_nx = dsm_pkg::ST_T_CHK;
				else if (s_last) state_nx = dsm_pkg::ST_PASS_END;
				else state_nx = dsm_pkg::ST_S_RD;
			end
			dsm_pkg::ST_T_CHK:    state_nx = (lb_rdata_a == ps_q) ? dsm_pkg::ST_A_RD : dsm_pkg::ST_T_RD;
			dsm_pkg::ST_A_RD:     state_nx = dsm_pkg::ST_A_LBL;
			dsm_pkg::ST_A_LBL:    state_nx = dsm_pkg::ST_A_CHK;
			dsm_pkg::ST_A_CHK: begin
				if (!sig_eq) state_nx = dsm_pkg::ST_T_RD;
				else if (!a_last) state_nx = dsm_pkg::ST_A_RD;
				else if (s_last) state_nx = dsm_pkg::ST_PASS_END;
				else state_nx = dsm_pkg::ST_S_RD;
			end
			dsm_pkg::ST_PASS_END: state_nx = changed_q ? dsm_pkg::ST_S_RD : dsm_pkg::ST_CNT_RD;
			dsm_pkg::ST_CNT_RD:   state_nx = dsm_pkg::ST_CNT_CHK;
			dsm_pkg::ST_CNT_CHK:  state_nx = s_last ? dsm_pkg::ST_OUT_RD : dsm_pkg::ST_CNT_RD;
			dsm_pkg::ST_OUT_RD:   state_nx = dsm_pkg::ST_OUT_ACC;
			dsm_pkg::ST_OUT_ACC:  state_nx = dsm_pkg::ST_OUT_SEND;
			dsm_pkg::ST_OUT_SEND: begin
				if (result_ready) state_nx = s_last ? dsm_pkg::ST_CLEAR : dsm_pkg::ST_OUT_RD;
			end
			default:              state_nx = dsm_pkg::ST_CLEAR;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		item_ready   = 1'b0;
		result_valid = 1'b0;
		tr_we      = 1'b0;
		tr_waddr   = clr_q;
		tr_wdata   = '0;
		tr_re      = 1'b0;
		tr_raddr_a = {s_q, a_q};
		tr_raddr_b = {t_q, a_q};
		ac_we      = 1'b0;
		ac_waddr   = SW'(clr_q);
		ac_wdata   = 1'b0;
		ac_re_a    = 1'b0;
		ac_raddr_a = s_q;
		ac_re_b    = 1'b0;
		ac_raddr_b = lb_rdata_a;
		lb_we      = 1'b0;
		lb_waddr   = s_q;
		lb_wdata   = t_q;
		lb_re_a    = 1'b0;
		lb_raddr_a = s_q;
		lb_re_b    = 1'b0;
		lb_raddr_b = SW'(tr_rdata_b[dsm_pkg::STATE_W-1:0]);
		case (state_q)
			dsm_pkg::ST_CLEAR: begin
				tr_we = 1'b1;
				ac_we = clr_acc_q && (32'(clr_q) < 32'(MAX_STATES));
			end
			dsm_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				tr_waddr   = {SW'(item.source_state), AW'(item.symbol_index)};
				tr_wdata   = {1'b1, item.target_state};
				tr_we      = item_valid && load_trans;
				ac_waddr   = SW'(item.source_state);
				ac_wdata   = item.is_accepting;
				ac_we      = item_valid && load_acc;
			end
			dsm_pkg::ST_INIT_RD: ac_re_a = 1'b1;
			dsm_pkg::ST_INIT_WR: begin
				lb_we    = 1'b1;
				lb_wdata = init_label;
			end
			dsm_pkg::ST_S_RD:    lb_re_a = 1'b1;
			dsm_pkg::ST_T_RD: begin
				lb_raddr_a = t_q;
				lb_re_a    = !t_eq_s;
				lb_we      = t_eq_s;
			end
			dsm_pkg::ST_A_RD:    tr_re = 1'b1;
			dsm_pkg::ST_A_LBL: begin
				lb_raddr_a = SW'(tr_rdata_a[dsm_pkg::STATE_W-1:0]);
				lb_re_a    = 1'b1;
				lb_re_b    = 1'b1;
			end
			dsm_pkg::ST_A_CHK:   lb_we = sig_eq && a_last;
			dsm_pkg::ST_CNT_RD:  lb_re_a = 1'b1;
			dsm_pkg::ST_OUT_RD:  lb_re_a = 1'b1;
			dsm_pkg::ST_OUT_ACC: ac_re_b = 1'b1;
			dsm_pkg::ST_OUT_SEND: result_valid = 1'b1;
			default: ;
		endcase
	end

	// result payload from held registers
	assign result.original_state  = dsm_pkg::STATE_W'(s_q);
	assign result.block_number    = dsm_pkg::STATE_W'(blk_q);
	assign result.block_accepting = ac_rdata_b;
	assign result.block_count     = dsm_pkg::COUNT_W'(count_q);
	assign result.last_result     = s_last;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// counters and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q        <= '0;
			t_q        <= '0;
			a_q        <= '0;
			clr_q      <= '0;
			clr_acc_q  <= 1'b1;
			rd_bank_q  <= 1'b0;
			changed_q  <= 1'b0;
			first0_v_q <= 1'b0;
			first1_v_q <= 1'b0;
			count_q    <= '0;
		end else begin
			case (state_q)
				dsm_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) clr_acc_q <= 1'b0;
				end
				dsm_pkg::ST_IDLE: begin
					s_q        <= '0;
					first0_v_q <= 1'b0;
					first1_v_q <= 1'b0;
					rd_bank_q  <= 1'b1;
				end
				dsm_pkg::ST_INIT_WR: begin
					if (ac_rdata_a && !first1_v_q) first1_v_q <= 1'b1;
					if (!ac_rdata_a && !first0_v_q) first0_v_q <= 1'b1;
					if (s_last) begin
						s_q       <= '0;
						rd_bank_q <= 1'b0;
						changed_q <= 1'b0;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				dsm_pkg::ST_S_RD: t_q <= '0;
				dsm_pkg::ST_T_RD: begin
					if (t_eq_s) begin
						if (s_q != ps_q) changed_q <= 1'b1;
						if (!s_last) s_q <= s_q + 1'b1;
					end
				end
				dsm_pkg::ST_T_CHK: begin
					if (lb_rdata_a == ps_q) a_q <= '0;
					else t_q <= t_q + 1'b1;
				end
				dsm_pkg::ST_A_CHK: begin
					if (!sig_eq) begin
						t_q <= t_q + 1'b1;
					end else if (!a_last) begin
						a_q <= a_q + 1'b1;
					end else begin
						if (t_q != ps_q) changed_q <= 1'b1;
						if (!s_last) s_q <= s_q + 1'b1;
					end
				end
				dsm_pkg::ST_PASS_END: begin
					s_q       <= '0;
					changed_q <= 1'b0;
					count_q   <= '0;
					if (changed_q) rd_bank_q <= !rd_bank_q;
				end
				dsm_pkg::ST_CNT_CHK: begin
					if (lb_rdata_a == s_q) count_q <= count_q + 1'b1;
					s_q <= s_last ? '0 : s_q + 1'b1;
				end
				dsm_pkg::ST_OUT_SEND: begin
					if (result_ready) begin
						s_q   <= s_q + 1'b1;
						clr_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == dsm_pkg::ST_INIT_WR) begin
			if (ac_rdata_a && !first1_v_q) first1_q <= s_q;
			if (!ac_rdata_a && !first0_v_q) first0_q <= s_q;
		end
		if (state_q == dsm_pkg::ST_S_LAT) ps_q <= lb_rdata_a;
		if (state_q == dsm_pkg::ST_A_LBL) begin
			pres_s_q <= pres_s;
			pres_t_q <= pres_t;
		end
		if (state_q == dsm_pkg::ST_OUT_ACC) blk_q <= lb_rdata_a;
	end

endmodule

### src/dfa_state_minimizer.sv
// ----------------------------------------------------------------------------
// dfa_state_minimizer
// Moore partition refinement of a loaded DFA, one result per original state.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) loads one transition and the
//   accepting flag of its source state per request, one request per cycle
//   while the block is idle. The request with last_entry set is stored and
//   then starts minimization; item_ready stays low until the job is done.
//   Refinement runs passes over the states; each pass compares a state with
//   lower states of its old block symbol by symbol, up to k symbols per compared
//   pair, reading the transition store and the label store through two
//   ports each. Passes repeat until no label changes.
//   Results then leave on the result channel (result_valid/result_ready/
//   result), one per original state in order, one at a time;
//   a stalled result holds its payload and the sequencer waits.
//   After the last result the transition store is swept clear, one entry per
//   cycle over all 2^(ceil(log2(MAX_STATES)) + ceil(log2(MAX_SYMBOLS)))
//   entries (1024 by default). The same sweep, also clearing the accepting
//   flags, runs after reset before the first request is taken.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
//   writes state_count (index 0) or symbol_count (index 1).
// ----------------------------------------------------------------------------
module dfa_state_minimizer #(
	parameter int unsigned MAX_STATES  = dsm_pkg::MAX_STATES_DEF,
	parameter int unsigned MAX_SYMBOLS = dsm_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dsm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  dsm_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output dsm_pkg::result_t                 result
);

	localparam int unsigned NW = $clog2(MAX_STATES+1);
	localparam int unsigned KW = $clog2(MAX_SYMBOLS+1);

	logic [dsm_pkg::COUNT_W-1:0]     state_count_q;
	logic [dsm_pkg::SYM_COUNT_W-1:0] symbol_count_q;
	logic [NW-1:0] n_eff;
	logic [KW-1:0] k_eff;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q  <= dsm_pkg::STATE_COUNT_RST;
			symbol_count_q <= dsm_pkg::SYMBOL_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dsm_pkg::CFG_STATE_COUNT:  state_count_q  <= cfg_data;
				dsm_pkg::CFG_SYMBOL_COUNT: symbol_count_q <= dsm_pkg::SYM_COUNT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// saturate counts to the store size
	always_comb begin
		if (state_count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(state_count_q) > 32'(MAX_STATES)) begin
			n_eff = NW'(MAX_STATES);
		end else begin
			n_eff = NW'(state_count_q);
		end
		if (symbol_count_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(symbol_count_q) > 32'(MAX_SYMBOLS)) begin
			k_eff = KW'(MAX_SYMBOLS);
		end else begin
			k_eff = KW'(symbol_count_q);
		end
	end

	dsm_seq #(.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS)) u_seq (
		.clk(clk), .arst_n(arst_n), .n_eff(n_eff), .k_eff(k_eff),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

endmodule
